/* src/sot_pkg.sv */
// ----------------------------------------------------------------------------
// sot_pkg - shared definitions for the shape overlap test
// Field widths and shape kind codes used by the datapath and the top level.
// ----------------------------------------------------------------------------
package sot_pkg;

   localparam int SIZE_BITS = 15;
   localparam int KIND_BITS = 2;
   localparam int RSP_BITS  = 8;

   typedef logic [KIND_BITS-1:0] kind_type;

   localparam kind_type KIND_RECT_RECT     = 2'd0;
   localparam kind_type KIND_RECT_CIRCLE   = 2'd1;
   localparam kind_type KIND_CIRCLE_CIRCLE = 2'd2;
   localparam kind_type KIND_UNUSED        = 2'd3;

endpackage

/* src/sot_eval.sv */
// ----------------------------------------------------------------------------
// sot_eval - overlap evaluation datapath
// Combinational rect-rect, rect-circle and circle-circle tests on one
// registered shape pair. Halves are avoided by doubling the other side.
// ----------------------------------------------------------------------------
module sot_eval #(
   parameter int COORD_BITS = 16
) (
   input  sot_pkg::kind_type                      kind,
   input  logic signed [COORD_BITS-1:0]           first_x,
   input  logic signed [COORD_BITS-1:0]           first_y,
   input  logic [sot_pkg::SIZE_BITS-1:0]          first_width,
   input  logic [sot_pkg::SIZE_BITS-1:0]          first_height,
   input  logic [sot_pkg::SIZE_BITS-1:0]          first_radius,
   input  logic signed [COORD_BITS-1:0]           second_x,
   input  logic signed [COORD_BITS-1:0]           second_y,
   input  logic [sot_pkg::SIZE_BITS-1:0]          second_width,
   input  logic [sot_pkg::SIZE_BITS-1:0]          second_height,
   input  logic [sot_pkg::SIZE_BITS-1:0]          second_radius,
   output logic                                   overlap
);
   import sot_pkg::*;

   // linear width holds 2*diff plus or minus a size with margin
   localparam int LW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 4;
   localparam int QW = 2 * LW;
   localparam int RW = SIZE_BITS + 2;
   localparam int RQ = 2 * RW;

   logic signed [LW-1:0] dx, dy, dx2, dy2;
   logic signed [LW-1:0] w1, h1, w2, h2, r2;
   logic signed [LW-1:0] adx2, ady2;
   logic signed [LW-1:0] ex, ey, aex, aey;
   logic signed [LW-1:0] sx, sy, asx, asy;
   logic [QW-1:0]        sq_dx, sq_dy, sq_ex, sq_ey;
   logic [QW:0]          dist_sq, corner_sq;
   logic [SIZE_BITS-1:0] big;
   logic [RW-1:0]        rad_sum, rad_dbl;
   logic [RQ-1:0]        sq_rad, sq_rdbl;
   logic                 near_hit, in_x, in_y, corner_hit, side_x, side_y;
   logic                 rr_hit, rc_hit, cc_hit;

   always_comb begin
      dx   = LW'(first_x) - LW'(second_x);
      dy   = LW'(first_y) - LW'(second_y);
      dx2  = dx <<< 1;
      dy2  = dy <<< 1;
      adx2 = (dx2 < 0) ? -dx2 : dx2;
      ady2 = (dy2 < 0) ? -dy2 : dy2;
      w1   = signed'(LW'(first_width));
      h1   = signed'(LW'(first_height));
      w2   = signed'(LW'(second_width));
      h2   = signed'(LW'(second_height));
      r2   = signed'(LW'({second_radius, 1'b0}));

      sq_dx   = QW'(unsigned'(adx2 >>> 1)) * QW'(unsigned'(adx2 >>> 1));
      sq_dy   = QW'(unsigned'(ady2 >>> 1)) * QW'(unsigned'(ady2 >>> 1));
      dist_sq = (QW+1)'(sq_dx) + (QW+1)'(sq_dy);

      // one squarer serves both the circle sum and the coarse reject bound
      big     = (first_width < first_height) ? first_height : first_width;
      rad_sum = (kind == KIND_CIRCLE_CIRCLE) ?
                RW'(first_radius) + RW'(second_radius) :
                RW'(big) + RW'(second_radius);
      sq_rad  = RQ'(rad_sum) * RQ'(rad_sum);
      near_hit = dist_sq < (QW+1)'(sq_rad);

      in_x = adx2 < w1;
      in_y = ady2 < h1;

      // circle left of rect center picks the low corner, else the high one
      ex  = (dx > 0) ? dx2 - w1 : dx2 + w1;
      ey  = (dy > 0) ? dy2 - h1 : dy2 + h1;
      aex = (ex < 0) ? -ex : ex;
      aey = (ey < 0) ? -ey : ey;
      sq_ex     = QW'(unsigned'(aex)) * QW'(unsigned'(aex));
      sq_ey     = QW'(unsigned'(aey)) * QW'(unsigned'(aey));
      corner_sq = (QW+1)'(sq_ex) + (QW+1)'(sq_ey);
      rad_dbl   = RW'({second_radius, 1'b0});
      sq_rdbl   = RQ'(rad_dbl) * RQ'(rad_dbl);
      corner_hit = corner_sq < (QW+1)'(sq_rdbl);

      sx  = (dx > 0) ? r2 - dx2 : -dx2 - r2;
      sy  = (dy > 0) ? r2 - dy2 : -dy2 - r2;
      asx = (sx < 0) ? -sx : sx;
      asy = (sy < 0) ? -sy : sy;
      side_x = in_y && (asx < w1);
      side_y = in_x && (asy < h1);

      rr_hit = (adx2 < w1 + w2) && (ady2 < h1 + h2);
      rc_hit = near_hit && ((in_x && in_y) || corner_hit || side_x || side_y);
      cc_hit = near_hit;

      case (kind)
         KIND_RECT_RECT:     overlap = rr_hit;
         KIND_RECT_CIRCLE:   overlap = rc_hit;
         KIND_CIRCLE_CIRCLE: overlap = cc_hit;
         default:            overlap = 1'b0;
      endcase
   end

endmodule

/* src/shape_overlap_test.sv */
// ----------------------------------------------------------------------------
// shape_overlap_test - 2D shape pair overlap test
// Usage:
//   req_* carries one shape pair per item; req_tuser holds the kind
//   (0 rect-rect, 1 rect vs circle, 2 circle-circle, 3 gives no overlap).
//   rsp_* returns one item per request with the overlap flag in bit 0.
//   An accepted item is held in the input register, then the test logic
//   loads the result register, whose valid flag drives rsp_tvalid.
//   Throughput is one item per cycle while rsp_tready stays high, set by
//   the single evaluation pass between the two registers; six squarers
//   work in parallel there.
//   A result waiting on rsp_tready does not block the input register:
//   a new item is taken while the result register is full, and req_tready
//   drops only when both registers hold items and rsp_tready is low.
//   Results leave in request order. Reset empties both registers; no
//   item is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module shape_overlap_test #(
   parameter int COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_x, first_y, first_width, first_height, first_radius,
   // second_x, second_y, second_width, second_height, second_radius, zero fill
   input  logic [((4*COORD_BITS+6*sot_pkg::SIZE_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  sot_pkg::kind_type req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // overlap, zero fill
   output logic [sot_pkg::RSP_BITS-1:0] rsp_tdata
);
   import sot_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int S   = SIZE_BITS;
   localparam int O_AX = 0;
   localparam int O_AY = O_AX + C;
   localparam int O_AW = O_AY + C;
   localparam int O_AH = O_AW + S;
   localparam int O_AR = O_AH + S;
   localparam int O_BX = O_AR + S;
   localparam int O_BY = O_BX + C;
   localparam int O_BW = O_BY + C;
   localparam int O_BH = O_BW + S;
   localparam int O_BR = O_BH + S;

   logic                  s1_valid_ff, s1_valid_in;
   kind_type              s1_kind_ff;
   logic signed [C-1:0]   s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic [S-1:0]          s1_aw_ff, s1_ah_ff, s1_ar_ff, s1_bw_ff, s1_bh_ff, s1_br_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_overlap_ff;
   logic                  eval_overlap;
   logic                  req_fire, advance;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_tuser;
         s1_ax_ff   <= req_tdata[O_AX +: C];
         s1_ay_ff   <= req_tdata[O_AY +: C];
         s1_aw_ff   <= req_tdata[O_AW +: S];
         s1_ah_ff   <= req_tdata[O_AH +: S];
         s1_ar_ff   <= req_tdata[O_AR +: S];
         s1_bx_ff   <= req_tdata[O_BX +: C];
         s1_by_ff   <= req_tdata[O_BY +: C];
         s1_bw_ff   <= req_tdata[O_BW +: S];
         s1_bh_ff   <= req_tdata[O_BH +: S];
         s1_br_ff   <= req_tdata[O_BR +: S];
      end
      if (advance) begin
         rsp_overlap_ff <= eval_overlap;
      end
   end

   sot_eval #(
      .COORD_BITS (COORD_BITS)
   ) u_eval (
      .kind          (s1_kind_ff),
      .first_x       (s1_ax_ff),
      .first_y       (s1_ay_ff),
      .first_width   (s1_aw_ff),
      .first_height  (s1_ah_ff),
      .first_radius  (s1_ar_ff),
      .second_x      (s1_bx_ff),
      .second_y      (s1_by_ff),
      .second_width  (s1_bw_ff),
      .second_height (s1_bh_ff),
      .second_radius (s1_br_ff),
      .overlap       (eval_overlap)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_BITS-1)'(0), rsp_overlap_ff};

   // empty input register always takes an item
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input register empty but not ready");

   // a moving item always lands in the result register
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register not loaded after advance");

   // both registers full and stalled: no new item may enter
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("item accepted while pipeline full and stalled");

   // unused kind code never reports overlap
   a_unused_kind: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_kind_ff == KIND_UNUSED) |=> !rsp_overlap_ff)
      else $error("unused kind produced overlap");

endmodule
